// File: rtl/core/fpq_pkg.sv
// Package with the shared types and constants of the frame presentation queue.
package fpq_pkg;

    localparam int SLOT_COUNT_DEF = 3;
    localparam int TIME_W = 48;
    localparam int FRAME_W = 16;
    localparam int COUNT_W = 32;
    localparam int MODE_W = 3;
    localparam int STATUS_W = 3;

    localparam logic [FRAME_W-1:0] NO_FRAME = '1;

    typedef logic [TIME_W-1:0] time_t;
    typedef logic [FRAME_W-1:0] frame_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_ENQUEUE = 3'd0,
        MODE_RENDER  = 3'd1,
        MODE_DONE    = 3'd2,
        MODE_ERROR   = 3'd3,
        MODE_START   = 3'd4,
        MODE_STOP    = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_IDLE     = 3'd0,
        ST_DECODING = 3'd1,
        ST_PLAYING  = 3'd2,
        ST_FINISHED = 3'd3,
        ST_ERROR    = 3'd4
    } status_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        frame_t            frame_number;
        time_t             frame_start_ns;
        time_t             now_ns;
    } item_t;

endpackage

// File: rtl/core/frame_presentation_queue.sv
// Top level of the frame presentation queue with slot state, counters and result register.
//
// Items arrive on the s_ channel (valid/ready) and each one yields exactly one result on
// the m_ channel (valid/ready). A transfer on the input lands in an input register; once
// the result register is free or being read, the core applies it to the slot and status
// state and loads the result register. One item per cycle is sustained while the
// receiver takes every result; the whole update for an item is one pass through the slot
// compare logic between the two registers. When the receiver stalls, the result register
// holds its result and the input register holds one more item; s_ready then drops until
// the result is taken. The clip duration is written through cfg_wr_en and cfg_wr_data;
// the user must write it only while the block is idle, which the block does not enforce.
// A synchronous low aresetn empties both registers, clears all slots and counters, sets
// the status to idle and the shown frame to none.
module frame_presentation_queue #(
    parameter int SLOT_COUNT = fpq_pkg::SLOT_COUNT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [fpq_pkg::TIME_W-1:0]      cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [fpq_pkg::MODE_W-1:0]      s_mode,
    input  logic [fpq_pkg::FRAME_W-1:0]     s_frame_number,
    input  logic [fpq_pkg::TIME_W-1:0]      s_frame_start_ns,
    input  logic [fpq_pkg::TIME_W-1:0]      s_now_ns,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_accepted,
    output logic                            m_shown,
    output logic [fpq_pkg::FRAME_W-1:0]     m_shown_frame,
    output logic [fpq_pkg::STATUS_W-1:0]    m_play_status,
    output logic [fpq_pkg::COUNT_W-1:0]     m_decoded_total,
    output logic [fpq_pkg::COUNT_W-1:0]     m_displayed_total,
    output logic [fpq_pkg::COUNT_W-1:0]     m_dropped_total
);

    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    fpq_pkg::item_t s_item;
    fpq_pkg::item_t item;
    logic           item_valid;
    logic           take;
    fpq_pkg::mode_t mode;

    fpq_pkg::time_t clip_reg;
    logic [SLOT_COUNT-1:0] ready_reg, ready_next;
    fpq_pkg::time_t  slot_start_reg [SLOT_COUNT];
    fpq_pkg::frame_t slot_frame_reg [SLOT_COUNT];
    logic              started_reg, started_next;
    logic              done_reg, done_next;
    fpq_pkg::time_t    stamp_reg, stamp_next;
    fpq_pkg::status_t  status_reg, status_next;
    fpq_pkg::count_t   decoded_reg, decoded_next;
    fpq_pkg::count_t   displayed_reg, displayed_next;
    fpq_pkg::count_t   dropped_reg, dropped_next;
    fpq_pkg::frame_t   frame_reg, frame_next;
    logic              m_valid_reg, m_valid_next;
    logic              accepted_reg, accepted_next;
    logic              shown_reg, shown_next;

    logic                  running;
    logic [SLOT_COUNT-1:0] free;
    logic [SLOT_COUNT-1:0] first_free;
    logic [SLOT_COUNT-1:0] wr_mask;
    fpq_pkg::time_t        elapsed;
    logic [SLOT_COUNT-1:0] sel;
    logic [SLOT_COUNT-1:0] drop;
    logic                  hit;
    logic [CNT_W-1:0]      drop_num;
    fpq_pkg::frame_t       sel_frame;

    assign s_item.mode           = s_mode;
    assign s_item.frame_number   = s_frame_number;
    assign s_item.frame_start_ns = s_frame_start_ns;
    assign s_item.now_ns         = s_now_ns;

    assign take = item_valid && (!m_valid_reg || m_ready);

    fpq_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    assign elapsed = item.now_ns - stamp_reg;

    fpq_slot_sel #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slot_sel (
        .slot_ready (ready_reg),
        .slot_start (slot_start_reg),
        .elapsed    (elapsed),
        .sel        (sel),
        .drop       (drop),
        .hit        (hit)
    );

    assign mode       = fpq_pkg::mode_t'(item.mode);
    assign running    = (status_reg == fpq_pkg::ST_DECODING || status_reg == fpq_pkg::ST_PLAYING)
                        && !done_reg;
    assign free       = ~ready_reg;
    assign first_free = free & (~free + SLOT_COUNT'(1));

    always_comb begin
        drop_num  = '0;
        sel_frame = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            drop_num  = drop_num + CNT_W'(drop[i]);
            sel_frame = sel_frame | (slot_frame_reg[i] & {fpq_pkg::FRAME_W{sel[i]}});
        end
    end

    always_comb begin
        ready_next     = ready_reg;
        started_next   = started_reg;
        done_next      = done_reg;
        stamp_next     = stamp_reg;
        status_next    = status_reg;
        decoded_next   = decoded_reg;
        displayed_next = displayed_reg;
        dropped_next   = dropped_reg;
        frame_next     = frame_reg;
        accepted_next  = 1'b0;
        shown_next     = 1'b0;
        wr_mask        = '0;
        case (mode)
            fpq_pkg::MODE_ENQUEUE: begin
                if (running && |free) begin
                    wr_mask      = first_free;
                    ready_next   = ready_reg | first_free;
                    decoded_next = decoded_reg + fpq_pkg::COUNT_W'(1);
                    if (!started_reg) begin
                        stamp_next   = item.now_ns;
                        started_next = 1'b1;
                        status_next  = fpq_pkg::ST_PLAYING;
                    end
                    accepted_next = 1'b1;
                end
            end
            fpq_pkg::MODE_RENDER: begin
                if (started_reg) begin
                    if (done_reg && elapsed >= clip_reg) begin
                        ready_next  = '0;
                        status_next = fpq_pkg::ST_FINISHED;
                    end else if (hit) begin
                        ready_next     = ready_reg & ~drop & ~sel;
                        frame_next     = sel_frame;
                        displayed_next = displayed_reg + fpq_pkg::COUNT_W'(1);
                        dropped_next   = dropped_reg + fpq_pkg::COUNT_W'(drop_num);
                        shown_next     = 1'b1;
                    end
                end
            end
            fpq_pkg::MODE_DONE: begin
                if (running) begin
                    done_next = 1'b1;
                end
            end
            fpq_pkg::MODE_ERROR: begin
                if (running) begin
                    status_next = fpq_pkg::ST_ERROR;
                    done_next   = 1'b1;
                end
            end
            fpq_pkg::MODE_START: begin
                ready_next     = '0;
                decoded_next   = '0;
                displayed_next = '0;
                dropped_next   = '0;
                done_next      = 1'b0;
                started_next   = 1'b0;
                frame_next     = fpq_pkg::NO_FRAME;
                status_next    = fpq_pkg::ST_DECODING;
            end
            fpq_pkg::MODE_STOP: begin
                ready_next   = '0;
                started_next = 1'b0;
                done_next    = 1'b0;
                status_next  = fpq_pkg::ST_IDLE;
            end
            default: begin
            end
        endcase
    end

    assign m_valid_next = take ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_reg      <= '0;
            ready_reg     <= '0;
            started_reg   <= 1'b0;
            done_reg      <= 1'b0;
            stamp_reg     <= '0;
            status_reg    <= fpq_pkg::ST_IDLE;
            decoded_reg   <= '0;
            displayed_reg <= '0;
            dropped_reg   <= '0;
            frame_reg     <= fpq_pkg::NO_FRAME;
            m_valid_reg   <= 1'b0;
            accepted_reg  <= 1'b0;
            shown_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                clip_reg <= cfg_wr_data;
            end
            m_valid_reg <= m_valid_next;
            if (take) begin
                ready_reg     <= ready_next;
                started_reg   <= started_next;
                done_reg      <= done_next;
                stamp_reg     <= stamp_next;
                status_reg    <= status_next;
                decoded_reg   <= decoded_next;
                displayed_reg <= displayed_next;
                dropped_reg   <= dropped_next;
                frame_reg     <= frame_next;
                accepted_reg  <= accepted_next;
                shown_reg     <= shown_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (take && wr_mask[i]) begin
                slot_start_reg[i] <= item.frame_start_ns;
                slot_frame_reg[i] <= item.frame_number;
            end
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_accepted        = accepted_reg;
    assign m_shown           = shown_reg;
    assign m_shown_frame     = frame_reg;
    assign m_play_status     = status_reg;
    assign m_decoded_total   = decoded_reg;
    assign m_displayed_total = displayed_reg;
    assign m_dropped_total   = dropped_reg;

endmodule

// File: rtl/core/fpq_in_stage.sv
// Input register stage that holds one accepted item until the core takes it.
module fpq_in_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  fpq_pkg::item_t s_item,
    input  logic          take,
    output logic          item_valid,
    output fpq_pkg::item_t item
);

    logic           valid_reg;
    logic           valid_next;
    fpq_pkg::item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: rtl/core/fpq_slot_sel.sv
// Parallel selection of the newest due slot and of the stale slots to drop.
module fpq_slot_sel #(
    parameter int SLOT_COUNT = fpq_pkg::SLOT_COUNT_DEF
) (
    input  logic [SLOT_COUNT-1:0] slot_ready,
    input  fpq_pkg::time_t        slot_start [SLOT_COUNT],
    input  fpq_pkg::time_t        elapsed,
    output logic [SLOT_COUNT-1:0] sel,
    output logic [SLOT_COUNT-1:0] drop,
    output logic                  hit
);

    logic [SLOT_COUNT-1:0] cand;
    logic [SLOT_COUNT-1:0] lt [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] eq [SLOT_COUNT];

    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            cand[i] = slot_ready[i] && (slot_start[i] <= elapsed);
            for (int j = 0; j < SLOT_COUNT; j++) begin
                lt[i][j] = slot_start[i] < slot_start[j];
                eq[i][j] = slot_start[i] == slot_start[j];
            end
        end
    end

    // A candidate wins when every other candidate starts earlier, or equal and in a lower slot.
    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            sel[i] = cand[i];
            for (int j = 0; j < SLOT_COUNT; j++) begin
                if (j != i && cand[j] && !(lt[j][i] || (eq[j][i] && j < i))) begin
                    sel[i] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        for (int j = 0; j < SLOT_COUNT; j++) begin
            drop[j] = slot_ready[j] && |(sel & lt[j]);
        end
    end

    assign hit = |sel;

endmodule

// File: tb/sv/tb_frame_presentation_queue.sv
`timescale 1ns / 100ps
// Self-checking testbench for the frame presentation queue, with its own playback predictor.
module tb_frame_presentation_queue;

    localparam int SLOTS = fpq_pkg::SLOT_COUNT_DEF;
    localparam fpq_pkg::time_t TIME_MAX = '1;
    localparam logic [fpq_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [fpq_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic             accepted;
        logic             shown;
        fpq_pkg::frame_t  frame;
        fpq_pkg::status_t status;
        fpq_pkg::count_t  decoded;
        fpq_pkg::count_t  displayed;
        fpq_pkg::count_t  dropped;
    } frame_report_t;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_wr_en;
    logic [fpq_pkg::TIME_W-1:0]     cfg_wr_data;
    logic                           s_valid;
    logic                           s_ready;
    logic [fpq_pkg::MODE_W-1:0]     s_mode;
    logic [fpq_pkg::FRAME_W-1:0]    s_frame_number;
    logic [fpq_pkg::TIME_W-1:0]     s_frame_start_ns;
    logic [fpq_pkg::TIME_W-1:0]     s_now_ns;
    logic                           m_valid;
    logic                           m_ready;
    logic                           m_accepted;
    logic                           m_shown;
    logic [fpq_pkg::FRAME_W-1:0]    m_shown_frame;
    logic [fpq_pkg::STATUS_W-1:0]   m_play_status;
    logic [fpq_pkg::COUNT_W-1:0]    m_decoded_total;
    logic [fpq_pkg::COUNT_W-1:0]    m_displayed_total;
    logic [fpq_pkg::COUNT_W-1:0]    m_dropped_total;

    frame_presentation_queue dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_frame_number    (s_frame_number),
        .s_frame_start_ns  (s_frame_start_ns),
        .s_now_ns          (s_now_ns),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_accepted        (m_accepted),
        .m_shown           (m_shown),
        .m_shown_frame     (m_shown_frame),
        .m_play_status     (m_play_status),
        .m_decoded_total   (m_decoded_total),
        .m_displayed_total (m_displayed_total),
        .m_dropped_total   (m_dropped_total)
    );

    // Predicted state of the queue.
    logic [SLOTS-1:0]  slot_busy;
    fpq_pkg::time_t    slot_start [SLOTS];
    fpq_pkg::frame_t   slot_frame [SLOTS];
    bit                playback_on;
    bit                decode_finished;
    fpq_pkg::time_t    playback_stamp;
    fpq_pkg::status_t  play_state;
    fpq_pkg::count_t   decoded_cnt;
    fpq_pkg::count_t   displayed_cnt;
    fpq_pkg::count_t   dropped_cnt;
    fpq_pkg::frame_t   on_screen;
    fpq_pkg::time_t    clip_len;

    frame_report_t expected_reports[$];
    int            mismatch_count = 0;
    int            sender_idle_pct = 0;
    int            receiver_stall_pct = 0;
    int            hold_requests = 0;
    int            hold_served = 0;
    int            quiet_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic fpq_pkg::time_t rand_time();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[fpq_pkg::TIME_W-1:0];
    endfunction

    function automatic fpq_pkg::item_t make_item(logic [fpq_pkg::MODE_W-1:0] op,
                                                 fpq_pkg::frame_t frame_no,
                                                 fpq_pkg::time_t start_ns,
                                                 fpq_pkg::time_t stamp_ns);
        fpq_pkg::item_t it;
        it.mode = op;
        it.frame_number = frame_no;
        it.frame_start_ns = start_ns;
        it.now_ns = stamp_ns;
        return it;
    endfunction

    function automatic frame_report_t present_item(fpq_pkg::item_t it);
        frame_report_t  r;
        fpq_pkg::time_t elapsed;
        fpq_pkg::time_t sel_start;
        int             sel;
        bit             producing;
        r = '0;
        sel = -1;
        sel_start = '0;
        producing = (play_state == fpq_pkg::ST_DECODING || play_state == fpq_pkg::ST_PLAYING)
                    && !decode_finished;
        case (it.mode)
            fpq_pkg::MODE_ENQUEUE: begin
                if (producing) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!r.accepted && !slot_busy[i]) begin
                            slot_busy[i] = 1'b1;
                            slot_start[i] = it.frame_start_ns;
                            slot_frame[i] = it.frame_number;
                            decoded_cnt++;
                            if (!playback_on) begin
                                playback_stamp = it.now_ns;
                                playback_on = 1'b1;
                                play_state = fpq_pkg::ST_PLAYING;
                            end
                            r.accepted = 1'b1;
                        end
                    end
                end
            end
            fpq_pkg::MODE_RENDER: begin
                if (playback_on) begin
                    elapsed = it.now_ns - playback_stamp;
                    if (decode_finished && elapsed >= clip_len) begin
                        slot_busy = '0;
                        play_state = fpq_pkg::ST_FINISHED;
                    end else begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (slot_busy[i] && slot_start[i] <= elapsed &&
                                (sel < 0 || slot_start[i] >= sel_start)) begin
                                sel = i;
                                sel_start = slot_start[i];
                            end
                        end
                        if (sel >= 0) begin
                            for (int i = 0; i < SLOTS; i++) begin
                                if (slot_busy[i] && slot_start[i] < sel_start) begin
                                    slot_busy[i] = 1'b0;
                                    dropped_cnt++;
                                end
                            end
                            slot_busy[sel] = 1'b0;
                            on_screen = slot_frame[sel];
                            displayed_cnt++;
                            r.shown = 1'b1;
                        end
                    end
                end
            end
            fpq_pkg::MODE_DONE: begin
                if (producing) begin
                    decode_finished = 1'b1;
                end
            end
            fpq_pkg::MODE_ERROR: begin
                if (producing) begin
                    play_state = fpq_pkg::ST_ERROR;
                    decode_finished = 1'b1;
                end
            end
            fpq_pkg::MODE_START: begin
                slot_busy = '0;
                decoded_cnt = '0;
                displayed_cnt = '0;
                dropped_cnt = '0;
                decode_finished = 1'b0;
                playback_on = 1'b0;
                on_screen = fpq_pkg::NO_FRAME;
                play_state = fpq_pkg::ST_DECODING;
            end
            fpq_pkg::MODE_STOP: begin
                slot_busy = '0;
                playback_on = 1'b0;
                decode_finished = 1'b0;
                play_state = fpq_pkg::ST_IDLE;
            end
            default: begin
            end
        endcase
        r.frame = on_screen;
        r.status = play_state;
        r.decoded = decoded_cnt;
        r.displayed = displayed_cnt;
        r.dropped = dropped_cnt;
        return r;
    endfunction

    task automatic flag_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        frame_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_reports.size() == 0) begin
                flag_mismatch("unexpected result transfer", 64'(m_shown_frame),
                              64'(fpq_pkg::NO_FRAME));
            end else begin
                want = expected_reports.pop_front();
                if (m_accepted !== want.accepted)
                    flag_mismatch("accepted", 64'(m_accepted), 64'(want.accepted));
                if (m_shown !== want.shown)
                    flag_mismatch("shown", 64'(m_shown), 64'(want.shown));
                if (m_shown_frame !== want.frame)
                    flag_mismatch("shown_frame", 64'(m_shown_frame), 64'(want.frame));
                if (m_play_status !== want.status)
                    flag_mismatch("play_status", 64'(m_play_status), 64'(want.status));
                if (m_decoded_total !== want.decoded)
                    flag_mismatch("decoded_total", 64'(m_decoded_total), 64'(want.decoded));
                if (m_displayed_total !== want.displayed)
                    flag_mismatch("displayed_total", 64'(m_displayed_total),
                                  64'(want.displayed));
                if (m_dropped_total !== want.dropped)
                    flag_mismatch("dropped_total", 64'(m_dropped_total), 64'(want.dropped));
            end
        end
    end

    // The receiver stalls at random, and holds off for a long stretch on request.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_requests != hold_served) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_served++;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_frame_presentation_queue: FAIL");
            $finish;
        end
    end

    task automatic offer_item(input fpq_pkg::item_t it);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= it.mode;
        s_frame_number <= it.frame_number;
        s_frame_start_ns <= it.frame_start_ns;
        s_now_ns <= it.now_ns;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_reports.push_back(present_item(it));
    endtask

    task automatic wait_reports_drained();
        s_valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
    endtask

    task automatic write_clip_length(input fpq_pkg::time_t len);
        wait_reports_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        clip_len = len;
    endtask

    // Opens with a start, then a mix of decoder, renderer and control events.
    task automatic run_playback_session(input int n_items);
        fpq_pkg::time_t  base;
        fpq_pkg::time_t  clock_off;
        fpq_pkg::time_t  next_start;
        fpq_pkg::frame_t next_frame;
        int              roll;
        fpq_pkg::item_t  it;
        base = ($urandom_range(0, 3) == 0) ?
               TIME_MAX - fpq_pkg::time_t'($urandom_range(0, 400)) : rand_time();
        clock_off = '0;
        next_start = fpq_pkg::time_t'($urandom_range(0, 20));
        next_frame = fpq_pkg::frame_t'($urandom_range(0, 100));
        offer_item(make_item(fpq_pkg::MODE_START, fpq_pkg::frame_t'(rand_time()),
                             rand_time(), rand_time()));
        for (int n = 1; n < n_items; n++) begin
            roll = $urandom_range(0, 99);
            it = make_item(fpq_pkg::MODE_RENDER, fpq_pkg::frame_t'(rand_time()), rand_time(),
                           base + clock_off);
            if (roll < 40) begin
                it.mode = fpq_pkg::MODE_ENQUEUE;
                if (roll < 3) begin
                    it.frame_number = fpq_pkg::frame_t'($urandom_range(0, 65535));
                end else begin
                    it.frame_number = next_frame;
                    next_frame++;
                end
                it.frame_start_ns = next_start;
                if ($urandom_range(0, 9) == 0 && next_start > fpq_pkg::time_t'(20))
                    it.frame_start_ns = next_start - fpq_pkg::time_t'($urandom_range(1, 20));
                next_start = next_start + fpq_pkg::time_t'($urandom_range(0, 30));
            end else if (roll < 80) begin
                clock_off = clock_off + fpq_pkg::time_t'($urandom_range(0, 40));
                it.now_ns = base + clock_off;
            end else if (roll < 86) begin
                it.mode = fpq_pkg::MODE_DONE;
            end else if (roll < 88) begin
                it.mode = fpq_pkg::MODE_ERROR;
            end else if (roll < 90) begin
                it.mode = fpq_pkg::MODE_STOP;
            end else if (roll < 92) begin
                it.mode = fpq_pkg::MODE_START;
            end else begin
                it = make_item(fpq_pkg::MODE_W'($urandom_range(0, 7)),
                               fpq_pkg::frame_t'($urandom_range(0, 65535)),
                               rand_time(), rand_time());
            end
            offer_item(it);
        end
    endtask

    task automatic test_directed_cases();
        fpq_pkg::time_t stamp;
        stamp = TIME_MAX - 10;
        offer_item(make_item(fpq_pkg::MODE_RENDER, 16'd0, 48'd0, 48'd0));
        offer_item(make_item(fpq_pkg::MODE_ENQUEUE, 16'd5, 48'd0, 48'd0));
        offer_item(make_item(MODE_SPARE_LO, '1, '1, '1));
        offer_item(make_item(MODE_SPARE_HI, '1, '1, '1));
        offer_item(make_item(fpq_pkg::MODE_START, 16'd0, 48'd0, 48'd0));
        offer_item(make_item(fpq_pkg::MODE_RENDER, 16'd0, 48'd0, stamp));
        offer_item(make_item(fpq_pkg::MODE_ENQUEUE, 16'd0, 48'd0, stamp));
        offer_item(make_item(fpq_pkg::MODE_ENQUEUE, fpq_pkg::NO_FRAME, 48'd5, stamp + 1));
        offer_item(make_item(fpq_pkg::MODE_ENQUEUE, 16'd7, 48'd5, stamp + 2));
        offer_item(make_item(fpq_pkg::MODE_ENQUEUE, 16'd9, 48'd1, stamp + 3));
        offer_item(make_item(fpq_pkg::MODE_RENDER, 16'd0, 48'd0, stamp + 5));
        offer_item(make_item(fpq_pkg::MODE_RENDER, 16'd0, 48'd0, 48'd2));
        offer_item(make_item(fpq_pkg::MODE_ENQUEUE, 16'hFFFE, TIME_MAX, 48'd3));
        offer_item(make_item(fpq_pkg::MODE_RENDER, 16'd0, 48'd0, stamp - 1));
        offer_item(make_item(fpq_pkg::MODE_ERROR, 16'd0, 48'd0, 48'd0));
        offer_item(make_item(fpq_pkg::MODE_ENQUEUE, 16'd11, 48'd0, 48'd0));
        offer_item(make_item(fpq_pkg::MODE_RENDER, 16'd0, 48'd0, stamp));
        offer_item(make_item(fpq_pkg::MODE_RENDER, 16'd0, 48'd0, stamp + 1));
        offer_item(make_item(fpq_pkg::MODE_DONE, 16'd0, 48'd0, 48'd0));
        offer_item(make_item(fpq_pkg::MODE_STOP, 16'd0, 48'd0, 48'd0));
        offer_item(make_item(fpq_pkg::MODE_START, 16'd0, 48'd0, 48'd0));
        offer_item(make_item(fpq_pkg::MODE_ENQUEUE, 16'd3, 48'd0, 48'd0));
        offer_item(make_item(fpq_pkg::MODE_DONE, 16'd0, 48'd0, 48'd0));
        offer_item(make_item(fpq_pkg::MODE_RENDER, 16'd0, 48'd0, 48'd0));
    endtask

    task automatic test_clip_extremes();
        write_clip_length(TIME_MAX);
        offer_item(make_item(fpq_pkg::MODE_START, 16'd0, 48'd0, 48'd0));
        offer_item(make_item(fpq_pkg::MODE_ENQUEUE, 16'd1, 48'd100, 48'd1000));
        offer_item(make_item(fpq_pkg::MODE_DONE, 16'd0, 48'd0, 48'd0));
        offer_item(make_item(fpq_pkg::MODE_RENDER, 16'd0, 48'd0, 48'd1050));
        offer_item(make_item(fpq_pkg::MODE_RENDER, 16'd0, 48'd0, 48'd999));
        write_clip_length('0);
        offer_item(make_item(fpq_pkg::MODE_START, 16'd0, 48'd0, 48'd0));
        offer_item(make_item(fpq_pkg::MODE_ENQUEUE, 16'd2, 48'd0, 48'd500));
        offer_item(make_item(fpq_pkg::MODE_DONE, 16'd0, 48'd0, 48'd0));
        offer_item(make_item(fpq_pkg::MODE_RENDER, 16'd0, 48'd0, 48'd500));
    endtask

    task automatic test_random_playback(input int idle_pct, input int stall_pct,
                                        input fpq_pkg::time_t len, input int n_items);
        int sent;
        int chunk;
        sent = 0;
        write_clip_length(len);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        while (sent < n_items) begin
            chunk = $urandom_range(15, 60);
            run_playback_session(chunk);
            sent += chunk;
        end
    endtask

    task automatic test_receiver_hold_off();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_requests++;
        run_playback_session(24);
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_mode = fpq_pkg::MODE_ENQUEUE;
        s_frame_number = '0;
        s_frame_start_ns = '0;
        s_now_ns = '0;
        slot_busy = '0;
        playback_on = 1'b0;
        decode_finished = 1'b0;
        playback_stamp = '0;
        play_state = fpq_pkg::ST_IDLE;
        decoded_cnt = '0;
        displayed_cnt = '0;
        dropped_cnt = '0;
        on_screen = fpq_pkg::NO_FRAME;
        clip_len = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_cases();
        test_clip_extremes();
        test_random_playback(0, 0, fpq_pkg::time_t'($urandom_range(0, 400)), 120);
        test_random_playback(49, 0, fpq_pkg::time_t'($urandom_range(0, 400)), 120);
        test_random_playback(0, 49, fpq_pkg::time_t'($urandom_range(0, 400)), 120);
        test_random_playback(25, 25, fpq_pkg::time_t'($urandom_range(0, 400)), 120);
        test_receiver_hold_off();

        wait_reports_drained();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_frame_presentation_queue: PASS");
        end else begin
            $display("tb_frame_presentation_queue: FAIL");
        end
        $finish;
    end
endmodule
